FILE: rtl/core/nco_pkg.sv
// ----------------------------------------------------------------------------
// NCO package
// Shared types and constants of the sine oscillator with phase accumulator.
// ----------------------------------------------------------------------------
package nco_pkg;

  localparam int unsigned PhaseW    = 32;
  localparam int unsigned FreqW     = 24;
  localparam int unsigned OffsetW   = 16;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned StepW     = 31;
  localparam int unsigned ProdW     = FreqW + StepW + 1;
  localparam int unsigned StepShift = 16;

  localparam logic [StepW-1:0] StepReset = 31'd22906492;
  localparam logic [63:0]      HalfPiQ30 = 64'd1686629713;

  localparam int unsigned CfgAddrW = 3;
  localparam logic        RegIdxStep = 1'b0;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [PhaseW-1:0]  delta;
    logic [OffsetW-1:0] phase_offset;
  } nco_entry_t;

  typedef struct packed {
    logic       valid;
    nco_entry_t entry;
  } nco_push_t;

endpackage

FILE: rtl/core/nco_in_if.sv
// ----------------------------------------------------------------------------
// NCO input channel
// Carries one sample tick: frequency and phase offset.
// ----------------------------------------------------------------------------
interface nco_in_if
  import nco_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FreqW-1:0]   freq_q8;
  logic [OffsetW-1:0] phase_offset;

  modport source (output valid, output freq_q8, output phase_offset, input ready);
  modport sink   (input valid, input freq_q8, input phase_offset, output ready);
endinterface

FILE: rtl/core/nco_out_if.sv
// ----------------------------------------------------------------------------
// NCO output channel
// Carries one signed Q1.15 sine sample.
// ----------------------------------------------------------------------------
interface nco_out_if
  import nco_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/core/nco_front.sv
// ----------------------------------------------------------------------------
// NCO front end
// Accepts a tick and registers the phase increment with the phase offset.
// ----------------------------------------------------------------------------
module nco_front
  import nco_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [StepW-1:0] step_i,
  nco_in_if.sink           in_ch_i,
  output nco_push_t        push_o,
  input  logic             push_ready_i
);

  logic                     valid_q, valid_d;
  nco_entry_t               entry_q;
  logic signed [ProdW-1:0]  prod;
  logic                     take;

  assign in_ch_i.ready = !valid_q || push_ready_i;
  assign take          = in_ch_i.valid && in_ch_i.ready;

  assign prod = ProdW'($signed(in_ch_i.freq_q8)) * ProdW'($signed({1'b0, step_i}));

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q.delta        <= prod[StepShift +: PhaseW];
      entry_q.phase_offset <= in_ch_i.phase_offset;
    end
  end

  assign push_o.valid = valid_q;
  assign push_o.entry = entry_q;

endmodule

FILE: rtl/core/nco_fifo.sv
// ----------------------------------------------------------------------------
// NCO queue
// Short queue that decouples the front end from the table lookup.
// ----------------------------------------------------------------------------
module nco_fifo
  import nco_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  nco_push_t push_i,
  output logic      push_ready_o,
  output nco_push_t pop_o,
  input  logic      pop_ready_i
);

  nco_entry_t           entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, rptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 push, pop;

  assign push_ready_o = count_q != QueueCntW'(QueueDepth);
  assign push         = push_i.valid && push_ready_o;
  assign pop_o.valid  = count_q != '0;
  assign pop_o.entry  = entries_q[rptr_q];
  assign pop          = pop_o.valid && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= push_i.entry;
    end
  end

endmodule

FILE: rtl/core/nco_back.sv
// ----------------------------------------------------------------------------
// NCO back end
// Phase accumulator, quarter-wave table lookup and output register.
// ----------------------------------------------------------------------------
module nco_back
  import nco_pkg::*;
#(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  nco_push_t pop_i,
  output logic      pop_ready_o,
  nco_out_if.source out_ch_o
);

  localparam int unsigned RomSize = 1 << TABLE_ADDR_BITS;

  typedef logic [SampleW-1:0] rom_t [RomSize];

  function automatic rom_t build_quarter_sine();
    rom_t                     rom;
    logic [63:0]              x;
    logic [63:0]              term;
    logic signed [63:0]       sum;
    logic [63:0]              scaled;
    for (int i = 0; i < RomSize; i++) begin
      x    = (HalfPiQ30 * 64'(2 * i + 1)) >> (TABLE_ADDR_BITS + 1);
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        case (k)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          6:       term = term / 64'd156;
          default: term = term / 64'd210;
        endcase
        if (k % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      if (sum > 64'sd1073741824) begin
        sum = 64'sd1073741824;
      end
      scaled = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
      rom[i] = scaled[SampleW-1:0];
    end
    return rom;
  endfunction

  localparam rom_t QuarterSine = build_quarter_sine();

  logic [PhaseW-1:0]          acc_q;
  logic [PhaseW-1:0]          phase;
  logic [TABLE_ADDR_BITS-1:0] addr;
  logic                       pop;

  logic                       s1_valid_q, s2_valid_q, s3_valid_q;
  logic [TABLE_ADDR_BITS-1:0] s1_addr_q;
  logic                       s1_neg_q, s2_neg_q;
  logic [SampleW-1:0]         s2_rom_q;
  logic signed [SampleW-1:0]  s3_sample_q;
  logic                       s1_ready, s2_ready, s3_ready;

  assign s3_ready    = !s3_valid_q || out_ch_o.ready;
  assign s2_ready    = !s2_valid_q || s3_ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign pop_ready_o = s1_ready;
  assign pop         = pop_i.valid && s1_ready;

  assign phase = acc_q + {pop_i.entry.phase_offset, StepShift'(0)};
  assign addr  = phase[PhaseW-2] ? ~phase[PhaseW-3 -: TABLE_ADDR_BITS]
                                 : phase[PhaseW-3 -: TABLE_ADDR_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        acc_q <= acc_q + pop_i.entry.delta;
      end
      if (s1_ready) begin
        s1_valid_q <= pop_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_addr_q <= addr;
      s1_neg_q  <= phase[PhaseW-1];
    end
    if (s2_ready && s1_valid_q) begin
      s2_rom_q <= QuarterSine[s1_addr_q];
      s2_neg_q <= s1_neg_q;
    end
    if (s3_ready && s2_valid_q) begin
      s3_sample_q <= s2_neg_q ? -$signed(s2_rom_q) : $signed(s2_rom_q);
    end
  end

  assign out_ch_o.valid  = s3_valid_q;
  assign out_ch_o.sample = s3_sample_q;

endmodule

FILE: rtl/core/sine_oscillator_phase_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Sine oscillator with phase accumulator
// Numerically controlled oscillator: one Q1.15 sine sample per tick.
// ----------------------------------------------------------------------------
//  Channel   Role   Contents
//  in_ch_i   sink   freq_q8 (s24), phase_offset (u16)
//  out_ch_o  source sample (s16, Q1.15)
//  APB       slave  step_per_hz (u31) at byte address 0
//
//  One item per cycle sustained while out_ch_o is ready; a result passes
//  the front register, the queue, the phase and address stage, the table
//  read and the output register. Reset clears the phase accumulator and
//  loads the default step; the table is constant. Either side may stall at
//  any time; the queue absorbs the difference.
// ----------------------------------------------------------------------------
module sine_oscillator_phase_accumulator_unit
  import nco_pkg::*;
#(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  nco_in_if.sink              in_ch_i,
  nco_out_if.source           out_ch_o
);

  logic [StepW-1:0] step_q;
  logic             step_wr;
  nco_push_t        push;
  logic             push_ready;
  nco_push_t        pop;
  logic             pop_ready;

  assign pready  = 1'b1;
  assign step_wr = psel && penable && pwrite && (paddr[CfgAddrW-1] == RegIdxStep);
  assign prdata  = (paddr[CfgAddrW-1] == RegIdxStep) ? {1'b0, step_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else if (step_wr) begin
      step_q <= pwdata[StepW-1:0];
    end
  end

  nco_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step_q),
    .in_ch_i      (in_ch_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  nco_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_o        (pop),
    .pop_ready_i  (pop_ready)
  );

  nco_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .pop_ready_o (pop_ready),
    .out_ch_o    (out_ch_o)
  );

  a_step_readback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_wr |=> step_q == $past(pwdata[StepW-1:0]))
    else $error("Step register did not take the written value.");

  a_accept_to_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch_i.valid && in_ch_i.ready |=> push.valid)
    else $error("Accepted transaction missing from the front stage.");

  a_front_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ch_i.valid && in_ch_i.ready) && !(push.valid && !push_ready) |=> !push.valid)
    else $error("Front stage holds a transaction that was never accepted.");

endmodule

FILE: tb/sv/sine_oscillator_phase_accumulator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sine oscillator testbench
// Drives sample ticks into the oscillator and predicts every sine sample from
// its own phase accumulator and quarter-wave table. The step register is
// rewritten between traffic phases, and both channels stall at random.
// ----------------------------------------------------------------------------
module sine_oscillator_phase_accumulator_unit_tb;
  import nco_pkg::*;

  localparam int unsigned AddrBits   = 10;
  localparam int unsigned RomDepth   = 1 << AddrBits;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxToneQ8  = 20000 * 256;

  localparam logic [CfgAddrW-1:0] StepAddr   = {RegIdxStep, 2'b00};
  localparam logic [CfgAddrW-1:0] UnusedAddr = 3'd4;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  nco_in_if  in_ch ();
  nco_out_if out_ch ();

  sine_oscillator_phase_accumulator_unit #(
    .TABLE_ADDR_BITS(AddrBits)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  logic signed [SampleW-1:0] quarter_wave [RomDepth];
  logic signed [SampleW-1:0] pending_samples [$];
  logic [PhaseW-1:0]         osc_phase;
  logic [StepW-1:0]          osc_step;
  int unsigned               error_count;
  int unsigned               stall_cycles;
  int unsigned               send_idle_pct;
  int unsigned               recv_idle_pct;

  always #4 clk_i = ~clk_i;

  function automatic logic signed [SampleW-1:0] quarter_sine(input int unsigned idx);
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    x    = (HalfPiQ30 * (2 * longint'(idx) + 1)) / (2 * longint'(RomDepth));
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
    return SampleW'((unsigned'(acc) * 32767 + (64'd1 << 29)) >> 30);
  endfunction

  // Forms the sample of one tick from the current phase, then advances it.
  task automatic record_tick(input logic [FreqW-1:0] f, input logic [OffsetW-1:0] o);
    logic [PhaseW-1:0]         p;
    logic [AddrBits-1:0]       a;
    logic signed [SampleW-1:0] v;
    longint                    prod;
    p = osc_phase + {o, 16'h0000};
    a = p[PhaseW-3 -: AddrBits];
    if (p[PhaseW-2]) a = ~a;
    v = quarter_wave[a];
    if (p[PhaseW-1]) v = -v;
    pending_samples = {pending_samples, v};
    prod = longint'($signed(f)) * longint'(osc_step);
    osc_phase = osc_phase + prod[47:16];
  endtask

  task automatic note_error(input string msg);
    if (error_count < 10) $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == StepAddr) osc_step = data[StepW-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_step_readback(input logic [31:0] want);
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= StepAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      note_error($sformatf("step readback expected %h actual %h", want, got));
    end
  endtask

  // Valid stays high after a transaction so that back-to-back ticks need no gap.
  task automatic send_tick(input logic [FreqW-1:0] f, input logic [OffsetW-1:0] o);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.freq_q8 <= FreqW'($urandom);
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.freq_q8      <= f;
    in_ch.phase_offset <= o;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    record_tick(f, o);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    logic [OffsetW-1:0] quadrant_offsets [8];
    quadrant_offsets = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                         16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
    check_step_readback({1'b0, StepReset});
    foreach (quadrant_offsets[i]) send_tick('0, quadrant_offsets[i]);
    wait_idle();
  endtask

  task automatic test_frequency_extremes();
    send_tick(24'h800000, 16'h0000);
    send_tick(24'h800000, 16'hFFFF);
    send_tick(24'h7FFFFF, 16'h0000);
    send_tick(24'hFFFFFF, 16'h8000);
    send_tick(24'h000001, 16'h4000);
    send_tick(24'h000100, 16'h0000);
    wait_idle();
  endtask

  task automatic test_step_register();
    apb_write(StepAddr, 32'h0000_0000);
    send_tick(24'h7FFFFF, 16'h0000);
    send_tick(24'h800000, 16'h5555);
    wait_idle();
    apb_write(StepAddr, 32'hFFFF_FFFF);
    check_step_readback(32'h7FFF_FFFF);
    send_tick(24'h7FFFFF, 16'h0000);
    send_tick(24'h800000, 16'hAAAA);
    send_tick(24'hFFFFFF, 16'h0000);
    wait_idle();
    apb_write(UnusedAddr, 32'h1234_5678);
    check_step_readback(32'h7FFF_FFFF);
    send_tick(24'h000001, 16'h0000);
    wait_idle();
  endtask

  // Mostly steady tones with a fixed or moving offset, mixed with random ticks.
  task automatic test_random_traffic(input int unsigned n_items, input logic [31:0] step);
    int unsigned        sent;
    int unsigned        burst;
    int unsigned        i;
    bit                 fixed_ofs;
    logic [FreqW-1:0]   f;
    logic [OffsetW-1:0] o;
    apb_write(StepAddr, step);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        f = FreqW'($urandom_range(MaxToneQ8));
        if ($urandom_range(1) == 1) f = -f;
        burst     = $urandom_range(40, 8);
        fixed_ofs = 1'($urandom_range(1));
        o         = OffsetW'($urandom);
        for (i = 0; i < burst && sent < n_items; i++) begin
          if (!fixed_ofs) o = OffsetW'($urandom);
          send_tick(f, o);
          sent++;
        end
      end else begin
        send_tick(FreqW'($urandom), OffsetW'($urandom));
        sent++;
      end
    end
    wait_idle();
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_samples
    logic signed [SampleW-1:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        note_error($sformatf("unexpected sample %0d", out_ch.sample));
      end else begin
        want = pending_samples.pop_front();
        if (out_ch.sample !== want) begin
          note_error($sformatf("sample expected %0d actual %0d", want, out_ch.sample));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.freq_q8      = '0;
    in_ch.phase_offset = '0;
    out_ch.ready       = 1'b0;
    error_count        = 0;
    stall_cycles       = 0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    osc_phase          = '0;
    osc_step           = StepReset;
    for (int i = 0; i < RomDepth; i++) quarter_wave[i] = quarter_sine(i);
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_frequency_extremes();
    test_step_register();

    send_idle_pct = 23;
    recv_idle_pct = 76;
    test_random_traffic(258, $urandom);
    test_random_traffic(258, {1'b0, StepReset});
    send_idle_pct = 76;
    recv_idle_pct = 23;
    test_random_traffic(258, $urandom);
    test_random_traffic(258, $urandom_range(1000, 1));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(258, 32'h7FFF_FFFF);
    test_random_traffic(258, $urandom);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/nco_pkg.sv
rtl/core/nco_in_if.sv
rtl/core/nco_out_if.sv
rtl/core/nco_front.sv
rtl/core/nco_fifo.sv
rtl/core/nco_back.sv
rtl/core/sine_oscillator_phase_accumulator_unit.sv
tb/sv/sine_oscillator_phase_accumulator_unit_tb.sv
